// ===== hw/rtl/rgbconv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types and constants of the rgb 3x3 convolution filter.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

   localparam int IMG_W_BITS   = 11;
   localparam int IMG_H_BITS   = 13;
   localparam int CHAN_BITS    = 8;
   localparam int PIX_BITS     = 3 * CHAN_BITS;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_MID    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KERNEL_BOTTOM = 3'd4;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PIX_BITS-1:0] pix;
   } item_type;

endpackage

// ===== hw/rtl/rgbconv_ram.sv =====
// ----------------------------------------------------------------------------
// rgbconv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgbconv_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rgbconv_front.sv =====
// ----------------------------------------------------------------------------
// rgbconv_front
// Accepts request transactions, tags them as pixel or drain and queues them.
// ----------------------------------------------------------------------------
module rgbconv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   output logic                  q_valid,
   output rgbconv_pkg::item_type q_item,
   input  logic                  q_pop
);
   import rgbconv_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);

   item_type         mem_ff [QDEPTH];
   logic [QPW-1:0]   wr_ptr_ff;
   logic [QPW-1:0]   rd_ptr_ff;
   logic [QPW:0]     cnt_ff;
   logic             push;
   logic             pop;
   item_type         new_item;

   assign req_stall = (cnt_ff == (QPW+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.op  = req_kind ? OP_DRAIN : OP_PIXEL;
      new_item.pix = {req_blue, req_green, req_red};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + (QPW+1)'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - (QPW+1)'(1);
         end
      end
   end

endmodule

// ===== hw/rtl/rgbconv_back.sv =====
// ----------------------------------------------------------------------------
// rgbconv_back
// Window, line stores, multiply-accumulate, divider and response register.
// ----------------------------------------------------------------------------
module rgbconv_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int COEF_BITS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rgbconv_pkg::IMG_W_BITS-1:0] cfg_width,
   input  logic [rgbconv_pkg::IMG_H_BITS-1:0] cfg_height,
   input  logic [3*COEF_BITS-1:0]            cfg_kernel_top,
   input  logic [3*COEF_BITS-1:0]            cfg_kernel_mid,
   input  logic [3*COEF_BITS-1:0]            cfg_kernel_bottom,
   input  logic                              q_valid,
   input  rgbconv_pkg::item_type             q_item,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_red,
   output logic [7:0]                        rsp_out_green,
   output logic [7:0]                        rsp_out_blue,
   output logic                              rsp_frame_end
);
   import rgbconv_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WXA = $clog2(MAX_WIDTH + 1);
   localparam int HXA = $clog2(MAX_HEIGHT + 1);
   localparam int WX  = (WXA > IMG_W_BITS) ? WXA : IMG_W_BITS;
   localparam int HX  = (HXA > IMG_H_BITS) ? HXA : IMG_H_BITS;
   localparam int PW  = WX + 1;
   localparam int PB  = COEF_BITS + CHAN_BITS + 1;
   localparam int AW  = COEF_BITS + CHAN_BITS + 5;
   localparam int KW  = COEF_BITS + 4;
   localparam int DCW = $clog2(AW);
   localparam int NTAP = 9;
   localparam int TW  = $clog2(NTAP);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_MAC,
      S_PREP,
      S_DIV,
      S_OUT
   } state_type;

   state_type              state_ff;

   logic [CW-1:0]          in_col_ff, out_col_ff, col_ff, pos_col_ff;
   logic [RW-1:0]          in_row_ff, out_row_ff, pos_row_ff;
   logic [PW-1:0]          pend_ff;
   logic [PIX_BITS-1:0]    pix_ff;
   logic                   wr_ff;
   logic                   emit_ff;
   logic                   fe_ff;

   logic [PIX_BITS-1:0]    win_ff   [3][3];
   logic [PIX_BITS-1:0]    patch_ff [NTAP];
   logic [TW-1:0]          tap_ff;

   logic signed [AW-1:0]   acc_ff [3];
   logic signed [KW-1:0]   ksum_ff;
   logic [AW-1:0]          num_ff [3];
   logic [KW-1:0]          rem_ff [3];
   logic [KW-1:0]          div_ff;
   logic [2:0]             neg_ff;
   logic [DCW-1:0]         dcnt_ff;

   logic                   rsp_valid_ff;
   logic [7:0]             rsp_chan_ff [3];
   logic                   rsp_fe_ff;

   // effective frame size and normalized positions
   logic [WX-1:0]          eff_w, w_ext;
   logic [HX-1:0]          eff_h, h_ext;
   logic [PW-1:0]          w_plus, pend_n;
   logic [CW-1:0]          in_col_n, out_col_n, in_col_nx, out_col_nx;
   logic [RW-1:0]          in_row_n, out_row_n, in_row_nx, out_row_nx;
   logic [WX-1:0]          in_col_inc, out_col_inc;
   logic [HX-1:0]          in_row_inc, out_row_inc;
   logic                   full;

   logic [2*PIX_BITS-1:0]  ram_rdata;
   logic [CW-1:0]          ram_raddr;
   logic                   ram_we;

   logic [PIX_BITS-1:0]    newcol [3];
   logic [PIX_BITS-1:0]    pat    [3][3];
   logic                   wrap;

   logic signed [COEF_BITS-1:0] coef_arr [NTAP];
   logic signed [COEF_BITS-1:0] coef_cur;
   logic signed [PB-1:0]        prod [3];
   logic [KW:0]                 trial [3];
   logic                        ge    [3];
   logic [KW-1:0]               rem_nx [3];
   logic [7:0]                  chan_res [3];

   always_comb begin
      w_ext = WX'(cfg_width);
      h_ext = HX'(cfg_height);
      if (w_ext == '0) begin
         eff_w = WX'(1);
      end else if (w_ext > WX'(MAX_WIDTH)) begin
         eff_w = WX'(MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end
      if (h_ext == '0) begin
         eff_h = HX'(1);
      end else if (h_ext > HX'(MAX_HEIGHT)) begin
         eff_h = HX'(MAX_HEIGHT);
      end else begin
         eff_h = h_ext;
      end

      in_col_n  = (WX'(in_col_ff)  >= eff_w) ? '0 : in_col_ff;
      out_col_n = (WX'(out_col_ff) >= eff_w) ? '0 : out_col_ff;
      in_row_n  = (HX'(in_row_ff)  >= eff_h) ? '0 : in_row_ff;
      out_row_n = (HX'(out_row_ff) >= eff_h) ? '0 : out_row_ff;
      w_plus    = PW'(eff_w) + PW'(1);
      pend_n    = (pend_ff > w_plus) ? w_plus : pend_ff;
      full      = (pend_n == w_plus);

      in_col_inc  = WX'(in_col_n) + WX'(1);
      out_col_inc = WX'(out_col_n) + WX'(1);
      in_row_inc  = HX'(in_row_n) + HX'(1);
      out_row_inc = HX'(out_row_n) + HX'(1);
      if (in_col_inc >= eff_w) begin
         in_col_nx = '0;
         in_row_nx = (in_row_inc >= eff_h) ? '0 : in_row_inc[RW-1:0];
      end else begin
         in_col_nx = in_col_inc[CW-1:0];
         in_row_nx = in_row_n;
      end
      if (out_col_inc >= eff_w) begin
         out_col_nx = '0;
         out_row_nx = (out_row_inc >= eff_h) ? '0 : out_row_inc[RW-1:0];
      end else begin
         out_col_nx = out_col_inc[CW-1:0];
         out_row_nx = out_row_n;
      end
   end

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign ram_raddr = (q_item.op == OP_PIXEL) ? in_col_n : out_col_nx;
   assign ram_we    = (state_ff == S_FETCH) && wr_ff;

   // line stores: upper row in the high half, lower row in the low half
   rgbconv_ram #(
      .WIDTH (2 * PIX_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_ff),
      .wr_data ({ram_rdata[PIX_BITS-1:0], pix_ff}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // neighborhood, taps outside the frame take the centre pixel
   always_comb begin
      wrap      = (col_ff == '0);
      newcol[0] = ram_rdata[2*PIX_BITS-1:PIX_BITS];
      newcol[1] = ram_rdata[PIX_BITS-1:0];
      newcol[2] = pix_ff;
      for (int i = 0; i < 3; i++) begin
         pat[i][0] = win_ff[i][1];
         pat[i][1] = win_ff[i][2];
         pat[i][2] = wrap ? win_ff[i][2] : newcol[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (pos_row_ff == '0) begin
            pat[0][i] = win_ff[1][2];
         end
         if (HX'(pos_row_ff) == eff_h - HX'(1)) begin
            pat[2][i] = win_ff[1][2];
         end
         if (pos_col_ff == '0) begin
            pat[i][0] = win_ff[1][2];
         end
         if (WX'(pos_col_ff) == eff_w - WX'(1)) begin
            pat[i][2] = win_ff[1][2];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef_arr[k]     = cfg_kernel_top[k*COEF_BITS +: COEF_BITS];
         coef_arr[3 + k] = cfg_kernel_mid[k*COEF_BITS +: COEF_BITS];
         coef_arr[6 + k] = cfg_kernel_bottom[k*COEF_BITS +: COEF_BITS];
      end
      coef_cur = coef_arr[tap_ff];
      for (int c = 0; c < 3; c++) begin
         prod[c]   = $signed({1'b0, patch_ff[0][c*CHAN_BITS +: CHAN_BITS]}) * coef_cur;
         trial[c]  = {rem_ff[c], num_ff[c][AW-1]};
         ge[c]     = (trial[c] >= {1'b0, div_ff});
         rem_nx[c] = ge[c] ? KW'(trial[c] - {1'b0, div_ff}) : trial[c][KW-1:0];
         if (neg_ff[c]) begin
            chan_res[c] = '0;
         end else if (num_ff[c] > AW'(CHAN_MAX)) begin
            chan_res[c] = CHAN_MAX;
         end else begin
            chan_res[c] = num_ff[c][CHAN_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  pos_col_ff <= out_col_n;
                  pos_row_ff <= out_row_n;
                  if (q_item.op == OP_PIXEL) begin
                     col_ff    <= in_col_n;
                     pix_ff    <= q_item.pix;
                     wr_ff     <= 1'b1;
                     emit_ff   <= full;
                     in_col_ff <= in_col_nx;
                     in_row_ff <= in_row_nx;
                     if (full) begin
                        out_col_ff <= out_col_nx;
                        out_row_ff <= out_row_nx;
                        pend_ff    <= pend_n;
                     end else begin
                        out_col_ff <= out_col_n;
                        out_row_ff <= out_row_n;
                        pend_ff    <= pend_n + PW'(1);
                     end
                     state_ff <= S_FETCH;
                  end else begin
                     in_col_ff <= in_col_n;
                     in_row_ff <= in_row_n;
                     if (pend_n != '0) begin
                        // drain: release the oldest owed result
                        col_ff     <= out_col_nx;
                        pix_ff     <= '0;
                        wr_ff      <= 1'b0;
                        emit_ff    <= 1'b1;
                        out_col_ff <= out_col_nx;
                        out_row_ff <= out_row_nx;
                        pend_ff    <= pend_n - PW'(1);
                        state_ff   <= S_FETCH;
                     end else begin
                        out_col_ff <= out_col_n;
                        out_row_ff <= out_row_n;
                        pend_ff    <= pend_n;
                     end
                  end
               end
            end
            S_FETCH: begin
               for (int i = 0; i < 3; i++) begin
                  win_ff[i][0] <= win_ff[i][1];
                  win_ff[i][1] <= win_ff[i][2];
                  win_ff[i][2] <= newcol[i];
                  for (int j = 0; j < 3; j++) begin
                     patch_ff[i*3 + j] <= pat[i][j];
                  end
               end
               fe_ff   <= (HX'(pos_row_ff) == eff_h - HX'(1)) &&
                          (WX'(pos_col_ff) == eff_w - WX'(1));
               tap_ff  <= '0;
               ksum_ff <= '0;
               for (int c = 0; c < 3; c++) begin
                  acc_ff[c] <= '0;
               end
               state_ff <= emit_ff ? S_MAC : S_IDLE;
            end
            S_MAC: begin
               for (int t = 0; t < NTAP - 1; t++) begin
                  patch_ff[t] <= patch_ff[t + 1];
               end
               for (int c = 0; c < 3; c++) begin
                  acc_ff[c] <= acc_ff[c] + AW'(prod[c]);
               end
               ksum_ff <= ksum_ff + KW'(coef_cur);
               tap_ff  <= tap_ff + TW'(1);
               if (tap_ff == TW'(NTAP - 1)) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               // a zero kernel sum divides by one
               if (ksum_ff == '0) begin
                  div_ff <= KW'(1);
               end else begin
                  div_ff <= ksum_ff[KW-1] ? KW'(-ksum_ff) : KW'(ksum_ff);
               end
               for (int c = 0; c < 3; c++) begin
                  num_ff[c] <= acc_ff[c][AW-1] ? AW'(-acc_ff[c]) : AW'(acc_ff[c]);
                  neg_ff[c] <= acc_ff[c][AW-1] ^ ksum_ff[KW-1];
                  rem_ff[c] <= '0;
               end
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division, quotient shifts into the dividend
               for (int c = 0; c < 3; c++) begin
                  rem_ff[c] <= rem_nx[c];
                  num_ff[c] <= {num_ff[c][AW-2:0], ge[c]};
               end
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(AW - 1)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  for (int c = 0; c < 3; c++) begin
                     rsp_chan_ff[c] <= chan_res[c];
                  end
                  rsp_fe_ff <= fe_ff;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_chan_ff[0];
   assign rsp_out_green = rsp_chan_ff[1];
   assign rsp_out_blue  = rsp_chan_ff[2];
   assign rsp_frame_end = rsp_fe_ff;

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

   a_fetch_after_pop : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> $past(q_pop))
      else $error("fetch without a popped transaction");

   a_div_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff <= DCW'(AW - 1)))
      else $error("divider ran past its step count");

   a_mac_to_prep : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC && tap_ff == TW'(NTAP - 1)) |=> (state_ff == S_PREP))
      else $error("accumulation did not end after the last tap");

endmodule

// ===== hw/rtl/rgb_3x3_convolution_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter
// Streaming 3x3 convolution of an rgb raster with kernel-sum normalization.
// ----------------------------------------------------------------------------
// path: a result transaction follows its request through the queue, the fetch
//   state, the mac, the prep state, the divider and the output register
// flow: the back end pops a new item only once it is through with the last, and
//   may hold in its output state on rsp_stall; the 9-tap mac and the
//   COEF_BITS+13 step radix-2 divider take one tap or one quotient bit per cycle
// reset: synchronous; clears state, positions, window, response valid and sets the
//   csr registers to their defaults, line stores and datapath are not cleared
module rgb_3x3_convolution_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int COEF_BITS  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [7:0]                            req_red,
   input  logic [7:0]                            req_green,
   input  logic [7:0]                            req_blue,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_out_red,
   output logic [7:0]                            rsp_out_green,
   output logic [7:0]                            rsp_out_blue,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_we,
   input  logic [rgbconv_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [((3*COEF_BITS > 13) ? 3*COEF_BITS : 13)-1:0] csr_wdata
);
   import rgbconv_pkg::*;

   localparam int KB = 3 * COEF_BITS;

   logic [IMG_W_BITS-1:0] width_ff;
   logic [IMG_H_BITS-1:0] height_ff;
   logic [KB-1:0]         ktop_ff, kmid_ff, kbot_ff;
   logic                  q_valid;
   logic                  q_pop;
   item_type              q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_W_BITS'(640);
         height_ff <= IMG_H_BITS'(480);
         ktop_ff   <= KB'(1180929);
         kmid_ff   <= KB'(132098);
         kbot_ff   <= KB'(65793);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[IMG_W_BITS-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata[IMG_H_BITS-1:0];
            CSR_KERNEL_TOP:    ktop_ff   <= csr_wdata[KB-1:0];
            CSR_KERNEL_MID:    kmid_ff   <= csr_wdata[KB-1:0];
            CSR_KERNEL_BOTTOM: kbot_ff   <= csr_wdata[KB-1:0];
            default: begin
            end
         endcase
      end
   end

   rgbconv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rgbconv_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COEF_BITS  (COEF_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg_width         (width_ff),
      .cfg_height        (height_ff),
      .cfg_kernel_top    (ktop_ff),
      .cfg_kernel_mid    (kmid_ff),
      .cfg_kernel_bottom (kbot_ff),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_frame_end     (rsp_frame_end)
   );

endmodule
